@@ hw/rtl/davidson_diagonal_preconditioner_core_assert.svh @@
// ----------------------------------------------------------------------------
// Davidson preconditioner assertion macros
// Shorthand for clocked assertions; clk and arst_n must be in scope.
// ----------------------------------------------------------------------------
`ifndef DAVIDSON_DIAGONAL_PRECONDITIONER_CORE_ASSERT_SVH
`define DAVIDSON_DIAGONAL_PRECONDITIONER_CORE_ASSERT_SVH

// same-cycle implication
`define DDP_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DDP_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/ddp_pkg.sv @@
// ----------------------------------------------------------------------------
// Davidson preconditioner package
// Shared types and constants for the controller, datapath and channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddp_pkg;

	localparam int NORM_W      = 64;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_EIGEN_VALUE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SMALL_LIMIT  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LANCZOS_MODE = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SETUP  = 5'b00010,
		ST_DIVIDE = 5'b00100,
		ST_SQUARE = 5'b01000,
		ST_ACCUM  = 5'b10000
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic step;
		logic square;
		logic accum;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic out_free;
	} status_t;

endpackage

@@ hw/rtl/ddp_if.sv @@
// ----------------------------------------------------------------------------
// Davidson preconditioner channels
// Valid/ready interfaces for input words, result words and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ddp_in_if #(parameter int VALUE_WIDTH = 32) ();
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] residual;
	logic signed [VALUE_WIDTH-1:0] diagonal;
	logic                          last_in_block;

	modport source (output valid, residual, diagonal, last_in_block, input ready);
	modport sink (input valid, residual, diagonal, last_in_block, output ready);
endinterface

interface ddp_out_if #(parameter int VALUE_WIDTH = 32) ();
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] scaled;
	logic [ddp_pkg::NORM_W-1:0]    square_sum;
	logic                          was_zeroed;
	logic                          saturated;
	logic                          block_end;

	modport source (output valid, scaled, square_sum, was_zeroed, saturated, block_end,
		input ready);
	modport sink (input valid, scaled, square_sum, was_zeroed, saturated, block_end,
		output ready);
endinterface

interface ddp_cfg_if #(parameter int VALUE_WIDTH = 32) ();
	logic                            valid;
	logic                            ready;
	logic [ddp_pkg::CFG_INDEX_W-1:0] index;
	logic [VALUE_WIDTH-1:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/davidson_diagonal_preconditioner_core.sv @@
// ----------------------------------------------------------------------------
// Davidson diagonal preconditioner core
// Scales residual words by 1 / (lambda - diagonal), or by one in Lanczos mode, and tracks the block norm.
//
// Channels: "in" takes residual, diagonal and last_in_block words; "out"
// returns scaled, square_sum, was_zeroed, saturated and block_end; "cfg"
// writes eigen_value (index 0), small_limit (1) and lanczos_mode (2), is
// always ready and must only be used while the core is idle.
// A word accepted from "in" passes through setup, the divider steps,
// squaring and accumulation before its result is registered for "out";
// a zeroed or out-of-range word skips the divider.
// The core holds one word at a time and takes the next only once the
// last has left the accumulate step; the shared radix-2 divider works
// one quotient bit per cycle.
// A finished result sits in the output register while the next word is
// accepted and divided; when the receiver stalls, the following result
// waits in the accumulate step and the input stops taking words.
// Reset clears the norm, restores the register defaults (eigen_value 0,
// small_limit 1, Davidson mode) and leaves the core idle and ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module davidson_diagonal_preconditioner_core #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ddp_in_if.sink      in,
	ddp_out_if.source   out,
	ddp_cfg_if.sink     cfg
);

	ddp_pkg::cmd_t    cmd;
	ddp_pkg::status_t status;
	logic             in_ready;

	assign in.ready  = in_ready;
	assign cfg.ready = 1'b1;

	ddp_ctrl #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	ddp_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.in_residual      (in.residual),
		.in_diagonal      (in.diagonal),
		.in_last_in_block (in.last_in_block),
		.cfg_valid        (cfg.valid),
		.cfg_index        (cfg.index),
		.cfg_data         (cfg.data),
		.out_valid        (out.valid),
		.out_ready        (out.ready),
		.out_scaled       (out.scaled),
		.out_square_sum   (out.square_sum),
		.out_was_zeroed   (out.was_zeroed),
		.out_saturated    (out.saturated),
		.out_block_end    (out.block_end)
	);

endmodule

@@ hw/rtl/ddp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Davidson preconditioner controller
// Sequences load, setup, shared divider iterations, squaring and accumulation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddp_ctrl #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ddp_pkg::status_t status,
	output ddp_pkg::cmd_t    cmd
);

	localparam int CNTW = $clog2(VALUE_WIDTH);

	ddp_pkg::state_t state_q, state_d;
	logic [CNTW-1:0] cnt_q, cnt_d;

	assign in_ready = (state_q == ddp_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			ddp_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ddp_pkg::ST_SETUP;
				end
			end
			ddp_pkg::ST_SETUP: begin
				cmd.setup = 1'b1;
				cnt_d     = CNTW'(VALUE_WIDTH - 1);
				state_d   = status.skip ? ddp_pkg::ST_SQUARE : ddp_pkg::ST_DIVIDE;
			end
			ddp_pkg::ST_DIVIDE: begin
				cmd.step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ddp_pkg::ST_SQUARE;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ddp_pkg::ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = ddp_pkg::ST_ACCUM;
			end
			ddp_pkg::ST_ACCUM: begin
				if (status.out_free) begin
					cmd.accum = 1'b1;
					state_d   = ddp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ddp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ddp_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

@@ hw/rtl/ddp_datapath.sv @@
// ----------------------------------------------------------------------------
// Davidson preconditioner datapath
// Registers, radix-2 restoring divider, squarer and saturating norm.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddp_datapath #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ddp_pkg::cmd_t                   cmd,
	output ddp_pkg::status_t                status,
	input  logic signed [VALUE_WIDTH-1:0]   in_residual,
	input  logic signed [VALUE_WIDTH-1:0]   in_diagonal,
	input  logic                            in_last_in_block,
	input  logic                            cfg_valid,
	input  logic [ddp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [VALUE_WIDTH-1:0]          cfg_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [VALUE_WIDTH-1:0]   out_scaled,
	output logic [ddp_pkg::NORM_W-1:0]      out_square_sum,
	output logic                            out_was_zeroed,
	output logic                            out_saturated,
	output logic                            out_block_end
);

	localparam int VW   = VALUE_WIDTH;
	localparam int NW   = VW + FRAC_BITS;
	localparam int MAGW = (VW + 1 > FRAC_BITS + 1) ? VW + 1 : FRAC_BITS + 1;
	localparam int DENW = MAGW + 1;
	localparam int CW   = (FRAC_BITS > MAGW) ? FRAC_BITS : MAGW;
	localparam int NRMW = ddp_pkg::NORM_W;

	localparam logic signed [DENW-1:0] UNIT_DEN = DENW'(1) << FRAC_BITS;
	localparam logic [VW-1:0]          LIM_NEG  = {1'b1, {(VW-1){1'b0}}};
	localparam logic [VW-1:0]          LIM_POS  = {1'b0, {(VW-1){1'b1}}};

	// configuration
	logic signed [VW-1:0] eigen_q;
	logic [VW-2:0]        limit_q;
	logic                 lanczos_q;

	// captured word
	logic signed [VW-1:0] res_q;
	logic signed [VW-1:0] diag_q;
	logic                 last_q;

	// divider
	logic [MAGW-1:0] dmag_q;
	logic [MAGW-1:0] rem_q;
	logic [VW-1:0]   lq_q;
	logic            neg_q;
	logic            zeroed_q;
	logic            ovf_q;

	// square stage
	logic signed [VW-1:0] scaled_q;
	logic [NRMW-1:0]      sq_q;
	logic                 sat_q;

	// norm and result
	logic [NRMW-1:0] acc_q;
	logic            out_vld_q;

	logic signed [DENW-1:0] den_d;
	logic [MAGW-1:0]        dmag_d;
	logic [VW-1:0]          nmag_d;
	logic [NW-1:0]          num_d;
	logic [FRAC_BITS-1:0]   num_hi_d;
	logic                   ovf_d;
	logic                   zeroed_d;
	logic                   neg_d;

	logic [MAGW:0]   rem_sh;
	logic            rem_ge;
	logic [MAGW-1:0] rem_next;

	logic [VW-1:0]   lim_d;
	logic            sat_d;
	logic [VW-1:0]   qc_d;
	logic [63:0]     qext_d;
	logic [63:0]     prod_d;
	logic [NRMW-1:0] sq_d;

	logic [NRMW:0]   sum_d;
	logic [NRMW-1:0] nrm_d;

	// setup: denominator, magnitudes, threshold and range check
	always_comb begin
		den_d    = lanczos_q ? UNIT_DEN : (DENW'(eigen_q) - DENW'(diag_q));
		dmag_d   = den_d[DENW-1] ? MAGW'(-den_d) : MAGW'(den_d);
		nmag_d   = res_q[VW-1] ? VW'(-res_q) : VW'(res_q);
		num_d    = {nmag_d, {FRAC_BITS{1'b0}}};
		num_hi_d = num_d[NW-1:VW];
		ovf_d    = CW'(num_hi_d) >= CW'(dmag_d);
		zeroed_d = !(dmag_d > MAGW'(limit_q));
		neg_d    = res_q[VW-1] ^ den_d[DENW-1];
	end

	assign status.skip     = zeroed_d || ovf_d;
	assign status.out_free = !out_vld_q || out_ready;

	// one restoring step
	always_comb begin
		rem_sh   = {rem_q, lq_q[VW-1]};
		rem_ge   = rem_sh >= {1'b0, dmag_q};
		rem_next = rem_ge ? MAGW'(rem_sh - {1'b0, dmag_q}) : MAGW'(rem_sh);
	end

	// clip and square
	always_comb begin
		lim_d  = neg_q ? LIM_NEG : LIM_POS;
		sat_d  = !zeroed_q && (ovf_q || (lq_q > lim_d));
		qc_d   = zeroed_q ? '0 : (sat_d ? lim_d : lq_q);
		qext_d = 64'(qc_d);
		prod_d = qext_d[31:0] * qext_d[31:0];
		sq_d   = (|qext_d[63:32]) ? {NRMW{1'b1}} : NRMW'(prod_d);
	end

	// saturating norm
	always_comb begin
		sum_d = {1'b0, acc_q} + {1'b0, sq_q};
		nrm_d = sum_d[NRMW] ? {NRMW{1'b1}} : sum_d[NRMW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eigen_q   <= '0;
			limit_q   <= (VW-1)'(1);
			lanczos_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ddp_pkg::CFG_EIGEN_VALUE:  eigen_q   <= cfg_data;
				ddp_pkg::CFG_SMALL_LIMIT:  limit_q   <= cfg_data[VW-2:0];
				ddp_pkg::CFG_LANCZOS_MODE: lanczos_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q  <= in_residual;
			diag_q <= in_diagonal;
			last_q <= in_last_in_block;
		end
		if (cmd.setup) begin
			dmag_q   <= dmag_d;
			rem_q    <= MAGW'(num_hi_d);
			lq_q     <= num_d[VW-1:0];
			neg_q    <= neg_d;
			zeroed_q <= zeroed_d;
			ovf_q    <= ovf_d;
		end else if (cmd.step) begin
			rem_q <= rem_next;
			lq_q  <= {lq_q[VW-2:0], rem_ge};
		end
		if (cmd.square) begin
			scaled_q <= neg_q ? VW'(-qc_d) : qc_d;
			sq_q     <= sq_d;
			sat_q    <= sat_d;
		end
		if (cmd.accum) begin
			out_scaled     <= scaled_q;
			out_square_sum <= nrm_d;
			out_was_zeroed <= zeroed_q;
			out_saturated  <= sat_q;
			out_block_end  <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.accum) begin
				acc_q     <= last_q ? '0 : nrm_d;
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;

endmodule

@@ hw/rtl/ddp_checker.sv @@
// ----------------------------------------------------------------------------
// Davidson preconditioner port checker
// Watches the top-level handshakes and flags illegal result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "davidson_diagonal_preconditioner_core_assert.svh"

module ddp_checker #(
	parameter int VALUE_WIDTH = 32
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [VALUE_WIDTH-1:0]     out_scaled,
	input logic [ddp_pkg::NORM_W-1:0] out_square_sum,
	input logic                       out_was_zeroed,
	input logic                       out_saturated
);

	localparam logic [VALUE_WIDTH-1:0] SMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] SMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	`DDP_ASSERT_NEXT(a_one_word_in_flight, in_valid && in_ready, !in_ready, "input taken while busy")
	`DDP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_scaled) && $stable(out_square_sum), "stalled word changed")
	`DDP_ASSERT_NOW(a_zeroed_clean, out_valid && out_was_zeroed, out_scaled == '0 && !out_saturated, "zeroed word not clean")
	`DDP_ASSERT_NOW(a_sat_extreme, out_valid && out_saturated, out_scaled == SMAX || out_scaled == SMIN, "saturated word not at limit")

endmodule

bind davidson_diagonal_preconditioner_core ddp_checker #(
	.VALUE_WIDTH (VALUE_WIDTH)
) u_ddp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in.valid),
	.in_ready       (in.ready),
	.out_valid      (out.valid),
	.out_ready      (out.ready),
	.out_scaled     (out.scaled),
	.out_square_sum (out.square_sum),
	.out_was_zeroed (out.was_zeroed),
	.out_saturated  (out.saturated)
);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Davidson diagonal preconditioner core testbench
// Drives residual/diagonal words through the core under several register
// settings and checks every result word, field by field, against an
// in-bench model of the division, zeroing, clipping and block norm.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam int VALUE_WIDTH = 32;
	localparam int FRAC_BITS = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = VALUE_WIDTH + 8;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_WORDS = 110;
	localparam logic [ddp_pkg::CFG_INDEX_W-1:0] CFG_NO_REGISTER = 2'd3;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] residual;
		logic signed [VALUE_WIDTH-1:0] diagonal;
		logic last_in_block;
	} element_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] scaled;
		logic [ddp_pkg::NORM_W-1:0] square_sum;
		logic was_zeroed;
		logic saturated;
		logic block_end;
	} scaled_word_t;

	bit clk;
	logic arst_n;

	ddp_in_if #(.VALUE_WIDTH(VALUE_WIDTH)) in_if ();
	ddp_out_if #(.VALUE_WIDTH(VALUE_WIDTH)) out_if ();
	ddp_cfg_if #(.VALUE_WIDTH(VALUE_WIDTH)) cfg_if ();

	davidson_diagonal_preconditioner_core #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_if),
		.out(out_if),
		.cfg(cfg_if)
	);

	logic signed [VALUE_WIDTH-1:0] lambda_reg;
	logic [VALUE_WIDTH-2:0] limit_reg;
	logic lanczos_reg;
	logic [ddp_pkg::NORM_W-1:0] block_norm;

	scaled_word_t expected_words[$];
	int error_count;
	int word_count;
	int stall_left;
	int idle_cycles;
	bit no_idle;

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_idle || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 50);
	endfunction

	function automatic logic signed [63:0] widen(logic signed [VALUE_WIDTH-1:0] v);
		return $signed({{(64 - VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v});
	endfunction

	function automatic scaled_word_t precondition_element(element_t e);
		scaled_word_t res;
		logic signed [63:0] den;
		logic signed [63:0] num_s;
		logic signed [63:0] signed_quot;
		logic [63:0] dmag;
		logic [63:0] num;
		logic [63:0] quot;
		logic [63:0] clip;
		logic [63:0] square;
		logic neg;
		res = '0;
		square = '0;
		if (lanczos_reg)
			den = 64'sd1 <<< FRAC_BITS;
		else
			den = widen(lambda_reg) - widen(e.diagonal);
		dmag = den[63] ? -den : den;
		res.was_zeroed = !(dmag > {{(65 - VALUE_WIDTH){1'b0}}, limit_reg});
		if (!res.was_zeroed) begin
			num_s = widen(e.residual);
			num = num_s[63] ? -num_s : num_s;
			neg = num_s[63] ^ den[63];
			clip = 64'd1 << (VALUE_WIDTH - 1);
			if (!neg)
				clip = clip - 64'd1;
			quot = (num << FRAC_BITS) / dmag;
			res.saturated = quot > clip;
			if (res.saturated)
				quot = clip;
			signed_quot = neg ? -$signed(quot) : $signed(quot);
			res.scaled = signed_quot[VALUE_WIDTH-1:0];
			square = (quot > 64'hFFFF_FFFF) ? '1 : quot * quot;
		end
		if (~block_norm < square)
			block_norm = '1;
		else
			block_norm = block_norm + square;
		res.square_sum = block_norm;
		res.block_end = e.last_in_block;
		if (e.last_in_block)
			block_norm = '0;
		return res;
	endfunction

	task automatic report_mismatch(string what);
		error_count++;
		$display("[%0t] MISMATCH word %0d: %s", $time, word_count, what);
	endtask

	task automatic feed_element(logic [VALUE_WIDTH-1:0] residual,
		logic [VALUE_WIDTH-1:0] diagonal, logic last_in_block);
		element_t e;
		int gap;
		e.residual = residual;
		e.diagonal = diagonal;
		e.last_in_block = last_in_block;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_if.valid <= 1'b1;
		in_if.residual <= e.residual;
		in_if.diagonal <= e.diagonal;
		in_if.last_in_block <= e.last_in_block;
		do @(posedge clk); while (!in_if.ready);
		expected_words.push_back(precondition_element(e));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_if.valid <= 1'b0;
		while (expected_words.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [ddp_pkg::CFG_INDEX_W-1:0] index,
		logic [VALUE_WIDTH-1:0] data);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= index;
		cfg_if.data <= data;
		do @(posedge clk); while (!cfg_if.ready);
		case (index)
			ddp_pkg::CFG_EIGEN_VALUE: lambda_reg = data;
			ddp_pkg::CFG_SMALL_LIMIT: limit_reg = data[VALUE_WIDTH-2:0];
			ddp_pkg::CFG_LANCZOS_MODE: lanczos_reg = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// reset values: lambda 0, limit 1, Davidson
	task automatic test_reset_defaults();
		feed_element(32'h0001_0000, 32'h0000_0000, 1'b0);
		feed_element(32'h0001_0000, 32'hFFFF_FFFF, 1'b0);
		feed_element(32'h0001_0000, 32'hFFFF_FFFE, 1'b0);
		feed_element(32'h8000_0000, 32'hFFFF_FFFE, 1'b0);
		feed_element(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		wait_idle();
	endtask

	task automatic test_extreme_denominators();
		write_reg(ddp_pkg::CFG_EIGEN_VALUE, 32'h7FFF_FFFF);
		write_reg(ddp_pkg::CFG_SMALL_LIMIT, 32'h0000_0000);
		feed_element(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		feed_element(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		feed_element(32'h8000_0000, 32'h7FFF_FFFE, 1'b0);
		feed_element(32'h0000_0000, 32'h0000_0000, 1'b0);
		feed_element(32'hFFFF_FFFF, 32'h1234_5678, 1'b1);
		wait_idle();
		write_reg(ddp_pkg::CFG_EIGEN_VALUE, 32'h8000_0000);
		feed_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		feed_element(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		wait_idle();
	endtask

	task automatic test_lanczos();
		write_reg(ddp_pkg::CFG_LANCZOS_MODE, 32'h0000_0001);
		write_reg(ddp_pkg::CFG_SMALL_LIMIT, 32'h0000_FFFF);
		feed_element(32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
		// four squares of the most negative value overflow the norm
		repeat (3) feed_element(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
		feed_element(32'h8000_0000, 32'h8000_0000, 1'b1);
		wait_idle();
		write_reg(ddp_pkg::CFG_SMALL_LIMIT, 32'h0001_0000);
		feed_element(32'h0000_1234, 32'h0000_0000, 1'b0);
		feed_element(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		wait_idle();
	endtask

	task automatic test_unused_index();
		write_reg(CFG_NO_REGISTER, 32'hFFFF_FFFF);
		write_reg(ddp_pkg::CFG_LANCZOS_MODE, 32'hFFFF_FFFE);
		write_reg(ddp_pkg::CFG_SMALL_LIMIT, 32'hFFFF_FFFF);
		feed_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		feed_element(32'h0001_0000, 32'h0000_0000, 1'b0);
		feed_element(32'h0001_0000, 32'hFFFF_FFFF, 1'b1);
		wait_idle();
	endtask

	task automatic test_random_blocks();
		logic [VALUE_WIDTH-1:0] residual;
		logic [VALUE_WIDTH-1:0] diagonal;
		int block_left;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			no_idle = (phase % 4 == 3);
			case ($urandom_range(0, 4))
				0: write_reg(ddp_pkg::CFG_EIGEN_VALUE, 32'h7FFF_FFFF);
				1: write_reg(ddp_pkg::CFG_EIGEN_VALUE, 32'h8000_0000);
				2: write_reg(ddp_pkg::CFG_EIGEN_VALUE, 32'h0000_0000);
				3: write_reg(ddp_pkg::CFG_EIGEN_VALUE, $urandom);
				default: write_reg(ddp_pkg::CFG_EIGEN_VALUE,
					$urandom_range(0, 2 ** 21) - 2 ** 20);
			endcase
			case ($urandom_range(0, 5))
				0: write_reg(ddp_pkg::CFG_SMALL_LIMIT, 32'h0000_0000);
				1: write_reg(ddp_pkg::CFG_SMALL_LIMIT,
					{1'($urandom_range(0, 1)), 31'h7FFF_FFFF});
				2: write_reg(ddp_pkg::CFG_SMALL_LIMIT, 32'h0000_FFFF);
				3: write_reg(ddp_pkg::CFG_SMALL_LIMIT, 32'h0001_0000);
				4: write_reg(ddp_pkg::CFG_SMALL_LIMIT, $urandom_range(0, 2 ** 18));
				default: write_reg(ddp_pkg::CFG_SMALL_LIMIT, $urandom);
			endcase
			write_reg(ddp_pkg::CFG_LANCZOS_MODE,
				VALUE_WIDTH'({$urandom, 1'($urandom_range(0, 3) == 0)}));
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_NO_REGISTER, $urandom);
			block_left = $urandom_range(1, 12);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: residual = $urandom_range(0, 2 ** 19) - 2 ** 18;
					5, 6, 7: residual = $urandom;
					8: residual = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
					default: residual = '0;
				endcase
				case ($urandom_range(0, 9))
					0, 1, 2, 3: diagonal = lambda_reg - ($urandom_range(0, 2 ** 18) - 2 ** 17);
					4: diagonal = lambda_reg - ($urandom_range(0, 16) - 8);
					5, 6, 7: diagonal = $urandom;
					8: diagonal = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
					default: diagonal = lambda_reg;
				endcase
				block_left--;
				feed_element(residual, diagonal, block_left == 0);
				if (block_left == 0)
					block_left = $urandom_range(1, 12);
			end
			wait_idle();
		end
		no_idle = 1'b0;
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		scaled_word_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				want = expected_words.pop_front();
				if (out_if.scaled !== want.scaled)
					report_mismatch($sformatf("scaled %h, want %h", out_if.scaled, want.scaled));
				if (out_if.square_sum !== want.square_sum)
					report_mismatch($sformatf("square_sum %h, want %h",
						out_if.square_sum, want.square_sum));
				if (out_if.was_zeroed !== want.was_zeroed)
					report_mismatch($sformatf("was_zeroed %b, want %b",
						out_if.was_zeroed, want.was_zeroed));
				if (out_if.saturated !== want.saturated)
					report_mismatch($sformatf("saturated %b, want %b",
						out_if.saturated, want.saturated));
				if (out_if.block_end !== want.block_end)
					report_mismatch($sformatf("block_end %b, want %b",
						out_if.block_end, want.block_end));
			end
			word_count++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
			|| (cfg_if.valid && cfg_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.residual = '0;
		in_if.diagonal = '0;
		in_if.last_in_block = 1'b0;
		out_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = ddp_pkg::CFG_EIGEN_VALUE;
		cfg_if.data = '0;
		lambda_reg = '0;
		limit_reg = (VALUE_WIDTH - 1)'(1);
		lanczos_reg = 1'b0;
		block_norm = '0;
		error_count = 0;
		word_count = 0;
		stall_left = 0;
		idle_cycles = 0;
		no_idle = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_extreme_denominators();
		test_lanczos();
		test_unused_index();
		test_random_blocks();
		wait_idle();
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
